FILE: rtl/core/pdre_pkg.sv
// ----------------------------------------------------------------------------
// pdre_pkg: shared types and constants of the page difference run encoder
// Configuration layout, result word layout, run kinds, status codes.
// ----------------------------------------------------------------------------
package pdre_pkg;

	localparam int RES_SLOTS = 4;
	localparam int CNT_W     = $clog2(RES_SLOTS + 1);
	localparam int SLOT_W    = $clog2(RES_SLOTS);
	localparam int CFG_W     = 17;
	localparam int IDX_W     = 2;

	localparam logic [16:0] COST_MAX  = 17'h1FFFF;
	localparam logic [15:0] ENTRY_MAX = 16'hFFFF;

	localparam logic [1:0] KIND_DIFF  = 2'd0;
	localparam logic [1:0] KIND_EQUAL = 2'd1;
	localparam logic [1:0] KIND_MARK  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUDGET  = 2'd1;
	localparam logic [1:0] ST_ENTRIES = 2'd2;

	localparam logic [IDX_W-1:0] REG_BUFFER_BYTES = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_BUDGET   = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_ENTRIES  = 2'd2;
	localparam logic [IDX_W-1:0] REG_ZERO_MODE    = 2'd3;

	typedef struct packed {
		logic [15:0] buffer_bytes;
		logic [16:0] max_diff_budget;
		logic [15:0] max_entries;
		logic        zero_mode;
	} pdre_cfg_t;

	typedef struct packed {
		logic        entry_valid;
		logic [15:0] run_length;
		logic [1:0]  run_kind;
		logic        is_last;
		logic [1:0]  status;
	} pdre_res_t;

	typedef struct packed {
		pdre_res_t [RES_SLOTS-1:0] res;
		logic [CNT_W-1:0]          cnt;
	} pdre_batch_t;

endpackage

FILE: rtl/core/pdre_ifs.sv
// ----------------------------------------------------------------------------
// pdre_ifs: valid/ready channels of the page difference run encoder
// Byte pair input channel and result word output channel.
// ----------------------------------------------------------------------------
interface pdre_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] old_byte;
	logic [7:0] new_byte;

	modport source (output valid, output old_byte, output new_byte, input ready);
	modport sink   (input valid, input old_byte, input new_byte, output ready);
endinterface

interface pdre_out_if;
	logic        valid;
	logic        ready;
	logic        entry_valid;
	logic [15:0] run_length;
	logic [1:0]  run_kind;
	logic        is_last;
	logic [1:0]  status;

	modport source (output valid, output entry_valid, output run_length, output run_kind,
		output is_last, output status, input ready);
	modport sink   (input valid, input entry_valid, input run_length, input run_kind,
		input is_last, input status, output ready);
endinterface

FILE: rtl/core/page_diff_run_encoder_core.sv
// ----------------------------------------------------------------------------
// page_diff_run_encoder_core: page difference run encoder
// Compares a page of old/new byte pairs and emits alternating run lengths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one old/new byte pair per word; out_ch carries result words
//   (run entries, zero-fill markers and one terminal word with the page status
//   after the last byte of each page).
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Path: a byte is registered in the input register at acceptance, and its
//   batch then goes into the result bank, which drives out_ch.
// Throughput: one byte per cycle while each byte yields at most one word and
//   out_ch takes each word at once; a byte yielding k words (up to 4) occupies
//   the result bank until its k words have gone, one word per out_ch handshake.
// Reset: arst_n clears the page state and the result bank; the registers take
//   buffer_bytes 4096 and zero in the others.
// Stall: while out_ch is held, one further byte waits in the input register,
//   then in_ch drops ready; nothing is lost.
// ----------------------------------------------------------------------------
module page_diff_run_encoder_core
	import pdre_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	pdre_in_if.sink          in_ch,
	pdre_out_if.source       out_ch
);

	pdre_cfg_t   cfg_q;
	pdre_batch_t batch;
	logic        batch_vld;
	logic        load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_bytes    <= 16'd4096;
			cfg_q.max_diff_budget <= 17'd0;
			cfg_q.max_entries     <= 16'd0;
			cfg_q.zero_mode       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUFFER_BYTES: cfg_q.buffer_bytes    <= cfg_data[15:0];
				REG_MAX_BUDGET:   cfg_q.max_diff_budget <= cfg_data[16:0];
				REG_MAX_ENTRIES:  cfg_q.max_entries     <= cfg_data[15:0];
				REG_ZERO_MODE:    cfg_q.zero_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pdre_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_ch     (in_ch),
		.load_ok   (load_ok),
		.batch_vld (batch_vld),
		.batch     (batch)
	);

	pdre_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch_vld (batch_vld),
		.batch     (batch),
		.load_ok   (load_ok),
		.out_ch    (out_ch)
	);

endmodule

FILE: rtl/core/pdre_step.sv
// ----------------------------------------------------------------------------
// pdre_step: input register, page state and run encoding logic
// Registers one byte pair, then in one pass updates the run, cost and entry
// counters and produces the batch of result words that the byte causes.
// ----------------------------------------------------------------------------
module pdre_step
	import pdre_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  pdre_cfg_t     cfg,
	pdre_in_if.sink       in_ch,
	input  logic          load_ok,
	output logic          batch_vld,
	output pdre_batch_t   batch
);

	logic       vld_s1;
	logic [7:0] old_s1;
	logic [7:0] new_s1;

	logic        eqph_q, anydiff_q, held_q;
	logic [15:0] run_q, bytes_q, ent_q;
	logic [16:0] cost_q;
	logic [1:0]  fail_q;

	logic        eqph_d, anydiff_d, held_d;
	logic [15:0] run_d, bytes_d, ent_d;
	logic [16:0] cost_d;
	logic [1:0]  fail_d;

	logic [15:0] size;
	logic [17:0] size_x3;
	logic [16:0] budget;
	logic [15:0] limit;
	logic        differs;
	logic        adv;
	logic [CNT_W-1:0] n;
	pdre_res_t [RES_SLOTS-1:0] res;

	function automatic logic [16:0] add_cost(logic [16:0] c, logic [15:0] r);
		logic [17:0] s;
		s = {1'b0, c} + {2'b00, r} + 18'd2;
		return (s > {1'b0, COST_MAX}) ? COST_MAX : s[16:0];
	endfunction

	assign adv          = vld_s1 && load_ok;
	assign in_ch.ready  = !vld_s1 || adv;
	assign batch_vld    = adv;
	assign batch.res    = res;
	assign batch.cnt    = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			old_s1 <= in_ch.old_byte;
			new_s1 <= in_ch.new_byte;
		end
	end

	always_comb begin
		size    = (cfg.buffer_bytes != 16'd0) ? cfg.buffer_bytes : 16'd1;
		size_x3 = {2'b00, size} + {1'b0, size, 1'b0};
		budget  = (cfg.max_diff_budget != 17'd0) ? cfg.max_diff_budget
			: {1'b0, size_x3[17:2]};
		limit   = (cfg.max_entries != 16'd0) ? cfg.max_entries : ENTRY_MAX;
		differs = cfg.zero_mode ? (new_s1 != 8'd0) : (old_s1 != new_s1);

		eqph_d    = eqph_q;
		anydiff_d = anydiff_q;
		held_d    = held_q;
		run_d     = run_q;
		bytes_d   = bytes_q;
		ent_d     = ent_q;
		cost_d    = cost_q;
		fail_d    = fail_q;
		n         = '0;
		res       = '0;

		if (bytes_d == 16'd0 && fail_d == ST_OK) begin
			if (cfg.zero_mode) begin
				res[n[SLOT_W-1:0]] = '{1'b1, 16'd0, KIND_MARK, 1'b0, ST_OK};
				n = n + 1'b1;
				res[n[SLOT_W-1:0]] = '{1'b1, 16'd0, KIND_MARK, 1'b0, ST_OK};
				n = n + 1'b1;
				ent_d = 16'd2;
			end
			if (ent_d >= limit) begin
				fail_d = ST_ENTRIES;
			end
		end

		if (fail_d == ST_OK) begin
			if (!eqph_d) begin
				if (differs) begin
					if (run_d != ENTRY_MAX) begin
						run_d = run_d + 16'd1;
					end
					anydiff_d = 1'b1;
				end else begin
					cost_d = add_cost(cost_d, run_d);
					if (cost_d > budget) begin
						fail_d = ST_BUDGET;
					end else begin
						if (run_d == 16'd0 && !cfg.zero_mode && !anydiff_d) begin
							held_d = 1'b1;
						end else begin
							res[n[SLOT_W-1:0]] = '{1'b1, run_d, KIND_DIFF, 1'b0, ST_OK};
							n = n + 1'b1;
						end
						if (ent_d != ENTRY_MAX) begin
							ent_d = ent_d + 16'd1;
						end
						eqph_d = 1'b1;
						run_d  = 16'd1;
					end
				end
			end else begin
				if (!differs) begin
					if (run_d != ENTRY_MAX) begin
						run_d = run_d + 16'd1;
					end
				end else begin
					if (held_d) begin
						res[n[SLOT_W-1:0]] = '{1'b1, 16'd0, KIND_DIFF, 1'b0, ST_OK};
						n = n + 1'b1;
						held_d = 1'b0;
					end
					res[n[SLOT_W-1:0]] = '{1'b1, run_d, KIND_EQUAL, 1'b0, ST_OK};
					n = n + 1'b1;
					if (ent_d != ENTRY_MAX) begin
						ent_d = ent_d + 16'd1;
					end
					if (ent_d >= limit) begin
						fail_d = ST_ENTRIES;
					end else begin
						eqph_d    = 1'b0;
						run_d     = 16'd1;
						anydiff_d = 1'b1;
					end
				end
			end
		end

		bytes_d = bytes_d + 16'd1;
		if (bytes_d >= size) begin
			if (fail_d == ST_OK && !eqph_d) begin
				cost_d = add_cost(cost_d, run_d);
				if (cost_d > budget) begin
					fail_d = ST_BUDGET;
				end else if (run_d != 16'd0) begin
					res[n[SLOT_W-1:0]] = '{1'b1, run_d, KIND_DIFF, 1'b0, ST_OK};
					n = n + 1'b1;
					if (ent_d != ENTRY_MAX) begin
						ent_d = ent_d + 16'd1;
					end
				end
			end
			res[n[SLOT_W-1:0]] = '{1'b0, 16'd0, KIND_DIFF, 1'b1, fail_d};
			n = n + 1'b1;
			eqph_d    = 1'b0;
			anydiff_d = 1'b0;
			held_d    = 1'b0;
			run_d     = 16'd0;
			bytes_d   = 16'd0;
			ent_d     = 16'd0;
			cost_d    = 17'd0;
			fail_d    = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eqph_q    <= 1'b0;
			anydiff_q <= 1'b0;
			held_q    <= 1'b0;
			run_q     <= 16'd0;
			bytes_q   <= 16'd0;
			ent_q     <= 16'd0;
			cost_q    <= 17'd0;
			fail_q    <= ST_OK;
		end else if (adv) begin
			eqph_q    <= eqph_d;
			anydiff_q <= anydiff_d;
			held_q    <= held_d;
			run_q     <= run_d;
			bytes_q   <= bytes_d;
			ent_q     <= ent_d;
			cost_q    <= cost_d;
			fail_q    <= fail_d;
		end
	end

endmodule

FILE: rtl/core/pdre_outq.sv
// ----------------------------------------------------------------------------
// pdre_outq: result register bank and output serializer
// Holds the batch of one byte and hands out one result word per handshake.
// ----------------------------------------------------------------------------
module pdre_outq
	import pdre_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          batch_vld,
	input  pdre_batch_t   batch,
	output logic          load_ok,
	pdre_out_if.source    out_ch
);

	logic [CNT_W-1:0]          cnt_q;
	logic [SLOT_W-1:0]         rd_q;
	pdre_res_t [RES_SLOTS-1:0] res_q;
	pdre_res_t                 head;
	logic                      fire;

	assign fire    = out_ch.valid && out_ch.ready;
	assign load_ok = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_ch.ready);
	assign head    = res_q[rd_q];

	assign out_ch.valid       = (cnt_q != '0);
	assign out_ch.entry_valid = head.entry_valid;
	assign out_ch.run_length  = head.run_length;
	assign out_ch.run_kind    = head.run_kind;
	assign out_ch.is_last     = head.is_last;
	assign out_ch.status      = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (batch_vld) begin
			cnt_q <= batch.cnt;
			rd_q  <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q - 1'b1;
			rd_q  <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_vld) begin
			res_q <= batch.res;
		end
	end

endmodule

FILE: rtl/core/pdre_checker.sv
// ----------------------------------------------------------------------------
// pdre_checker: port level checks of the page difference run encoder
// Watches the result channel for word hold and result word consistency.
// ----------------------------------------------------------------------------
module pdre_checker
	import pdre_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        entry_valid,
	input logic [15:0] run_length,
	input logic [1:0]  run_kind,
	input logic        is_last,
	input logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_length))
		else $error("result word dropped or changed while stalled");

	a_entry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_valid |-> !is_last && status == ST_OK)
		else $error("entry word carries terminal fields");

	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> run_length == 16'd0
			&& run_kind == KIND_DIFF && status <= ST_ENTRIES)
		else $error("terminal word malformed");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_kind == KIND_MARK |-> entry_valid
			&& run_length == 16'd0)
		else $error("zero-fill marker malformed");

endmodule

bind page_diff_run_encoder_core pdre_checker u_pdre_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.entry_valid (out_ch.entry_valid),
	.run_length  (out_ch.run_length),
	.run_kind    (out_ch.run_kind),
	.is_last     (out_ch.is_last),
	.status      (out_ch.status)
);
